@@ rtl/core/kptar_pkg.sv @@
// kptar_pkg: shared types and constants for the keyed packet table core.
// Used by kptar_slot_store and keyed_packet_table_age_replace_core.
// No dependencies.
`timescale 1ns / 1ps

package kptar_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam int ADDR_W = 14;
    localparam int KIND_W = 4;
    localparam int RPT_W  = 8;
    localparam int PLD_W  = 48;
    localparam int LEN_W  = 3;
    localparam int AGE_W  = 8;
    localparam int CFG_W  = 5;

    localparam logic [AGE_W-1:0] AGE_MAX = 8'd255;
    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 5'd10;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_FORGET = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [KIND_W-1:0] kind;
        logic [RPT_W-1:0]  rpt;
        logic [PLD_W-1:0]  payload;
        logic [LEN_W-1:0]  len;
    } kptar_entry_t;

    typedef struct packed {
        logic             valid;
        logic [AGE_W-1:0] age;
        kptar_entry_t     entry;
    } kptar_slot_rd_t;

    typedef struct packed {
        logic             wr_entry;
        logic             wr_age;
        logic             clr_valid;
        logic [IDX_W-1:0] idx;
        logic [AGE_W-1:0] age;
        kptar_entry_t     entry;
    } kptar_slot_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_AGE,
        ST_FORGET,
        ST_READ,
        ST_MOD
    } kptar_state_t;

endpackage

@@ rtl/core/kptar_slot_store.sv @@
// kptar_slot_store: slot register file with per-slot valid bits and ages.
// Empty slots read as zero contents with age 255. Depends on kptar_pkg.
`timescale 1ns / 1ps

module kptar_slot_store (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [kptar_pkg::IDX_W-1:0]       rd_idx,
    output kptar_pkg::kptar_slot_rd_t         rd,
    input  kptar_pkg::kptar_slot_wr_t         wr
);

    kptar_pkg::kptar_entry_t        entry_reg [kptar_pkg::SLOTS];
    logic [kptar_pkg::AGE_W-1:0]    age_reg   [kptar_pkg::SLOTS];
    logic [kptar_pkg::SLOTS-1:0]    valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.wr_entry)
        begin
            valid_reg[wr.idx] <= 1'b1;
        end
        else if (wr.clr_valid)
        begin
            valid_reg[wr.idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.wr_entry)
        begin
            entry_reg[wr.idx] <= wr.entry;
        end
        if (wr.wr_entry || wr.wr_age)
        begin
            age_reg[wr.idx] <= wr.age;
        end
    end

    always_comb
    begin
        rd.valid = valid_reg[rd_idx];
        rd.entry = valid_reg[rd_idx] ? entry_reg[rd_idx] : '0;
        rd.age   = valid_reg[rd_idx] ? age_reg[rd_idx] : kptar_pkg::AGE_MAX;
    end

endmodule

@@ rtl/core/keyed_packet_table_age_replace_core.sv @@
// keyed_packet_table_age_replace_core: keyed packet table, oldest-slot replace.
// Depends on kptar_pkg and kptar_slot_store.
//
// Usage:
//   A request (op, address, kind, repeat_req, payload, payload_len) is taken
//   at a clock edge with start high and busy low. busy stays high while the
//   sequencer walks the slots one per cycle; one result follows each request,
//   shown for exactly one cycle with done high. The receiver cannot stall.
//   cfg_we/cfg_data write slots_in_use (n); the user must do so only while the core is idle (not enforced).
// Sequence from accept to done (n = active slots, 1..16):
//   insert: scan up to the first key match (at most n slots), then an aging
//           pass over all n slots
//   forget: one slot compare per cycle over the n slots
//   read:   read the slot, then q subtract steps of the index wrap
//           (q at most 16); read of an empty table, or op 3, answered from idle
//   A new request may be taken in the cycle that done is high.
// Reset: all slots empty (age 255), count and read index zero, n = 10.
`timescale 1ns / 1ps

module keyed_packet_table_age_replace_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         op,
    input  logic [kptar_pkg::ADDR_W-1:0]       address,
    input  logic [kptar_pkg::KIND_W-1:0]       kind,
    input  logic [kptar_pkg::RPT_W-1:0]        repeat_req,
    input  logic [kptar_pkg::PLD_W-1:0]        payload,
    input  logic [kptar_pkg::LEN_W-1:0]        payload_len,
    input  logic                               cfg_we,
    input  logic [kptar_pkg::CFG_W-1:0]        cfg_data,
    output logic                               done,
    output logic                               ok,
    output logic                               updated_existing,
    output logic [kptar_pkg::ADDR_W-1:0]       out_address,
    output logic [kptar_pkg::KIND_W-1:0]       out_kind,
    output logic [kptar_pkg::RPT_W-1:0]        out_repeat,
    output logic [kptar_pkg::PLD_W-1:0]        out_payload,
    output logic [kptar_pkg::LEN_W-1:0]        out_payload_len,
    output logic                               out_slot_valid
);

    kptar_pkg::kptar_state_t        state_reg, state_next;
    logic [kptar_pkg::CFG_W-1:0]    siu_reg;
    logic [kptar_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [kptar_pkg::IDX_W-1:0]    pick_reg, pick_next;
    logic [kptar_pkg::AGE_W-1:0]    best_reg, best_next;
    logic                           match_reg, match_next;
    logic [kptar_pkg::CNT_W-1:0]    removed_reg, removed_next;
    logic [kptar_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [kptar_pkg::IDX_W-1:0]    rdidx_reg, rdidx_next;
    logic [kptar_pkg::CNT_W-1:0]    modv_reg, modv_next;
    logic [kptar_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [kptar_pkg::KIND_W-1:0]   kind_reg, kind_next;
    kptar_pkg::kptar_entry_t        req_reg, req_next;

    logic                           done_reg, done_next;
    logic                           ok_reg, ok_next;
    logic                           upd_reg, upd_next;
    kptar_pkg::kptar_entry_t        oent_reg, oent_next;
    logic                           ovld_reg, ovld_next;

    logic [kptar_pkg::CNT_W-1:0]    n_act;
    logic [kptar_pkg::IDX_W-1:0]    n_last;
    logic                           last;
    logic                           key_hit;
    logic                           addr_hit;
    logic [kptar_pkg::CNT_W-1:0]    rem_total;
    logic [kptar_pkg::IDX_W-1:0]    rd_idx;
    kptar_pkg::kptar_slot_rd_t      rd;
    kptar_pkg::kptar_slot_wr_t      wr;

    always_comb
    begin
        if (siu_reg == '0)
        begin
            n_act = kptar_pkg::CNT_W'(1);
        end
        else if (int'(siu_reg) > kptar_pkg::SLOTS)
        begin
            n_act = kptar_pkg::CNT_W'(kptar_pkg::SLOTS);
        end
        else
        begin
            n_act = kptar_pkg::CNT_W'(siu_reg);
        end
    end

    assign n_last    = kptar_pkg::IDX_W'(n_act - kptar_pkg::CNT_W'(1));
    assign last      = (idx_reg == n_last);
    assign rd_idx    = (state_reg == kptar_pkg::ST_READ) ? rdidx_reg : idx_reg;
    assign addr_hit  = rd.valid && (rd.entry.address == addr_reg);
    assign key_hit   = addr_hit && (rd.entry.kind == kind_reg);
    assign rem_total = removed_reg + kptar_pkg::CNT_W'(addr_hit);

    kptar_slot_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (rd_idx),
        .rd     (rd),
        .wr     (wr)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kptar_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        kptar_pkg::OP_INSERT: state_next = kptar_pkg::ST_INS_SCAN;
                        kptar_pkg::OP_FORGET: state_next = kptar_pkg::ST_FORGET;
                        kptar_pkg::OP_READ:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = kptar_pkg::ST_READ;
                            end
                        end
                        default: state_next = kptar_pkg::ST_IDLE;
                    endcase
                end
            end
            kptar_pkg::ST_INS_SCAN:
            begin
                if (key_hit || last)
                begin
                    state_next = kptar_pkg::ST_INS_AGE;
                end
            end
            kptar_pkg::ST_INS_AGE,
            kptar_pkg::ST_FORGET:
            begin
                if (last)
                begin
                    state_next = kptar_pkg::ST_IDLE;
                end
            end
            kptar_pkg::ST_READ:
            begin
                state_next = kptar_pkg::ST_MOD;
            end
            kptar_pkg::ST_MOD:
            begin
                if (modv_reg < count_reg)
                begin
                    state_next = kptar_pkg::ST_IDLE;
                end
            end
            default: state_next = kptar_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        idx_next     = idx_reg;
        pick_next    = pick_reg;
        best_next    = best_reg;
        match_next   = match_reg;
        removed_next = removed_reg;
        count_next   = count_reg;
        rdidx_next   = rdidx_reg;
        modv_next    = modv_reg;
        addr_next    = addr_reg;
        kind_next    = kind_reg;
        req_next     = req_reg;
        done_next    = 1'b0;
        ok_next      = ok_reg;
        upd_next     = upd_reg;
        oent_next    = oent_reg;
        ovld_next    = ovld_reg;
        wr           = '0;
        wr.idx       = idx_reg;
        wr.entry     = req_reg;

        unique case (state_reg)
            kptar_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    addr_next       = address;
                    kind_next       = kind;
                    req_next        = '{address, kind, repeat_req, payload, payload_len};
                    idx_next        = '0;
                    pick_next       = '0;
                    best_next       = '0;
                    match_next      = 1'b0;
                    removed_next    = '0;
                    if (!((op == kptar_pkg::OP_INSERT) || (op == kptar_pkg::OP_FORGET)
                          || ((op == kptar_pkg::OP_READ) && (count_reg != '0))))
                    begin
                        done_next = 1'b1;
                        ok_next   = 1'b0;
                        upd_next  = 1'b0;
                        oent_next = '0;
                        ovld_next = 1'b0;
                    end
                end
            end
            kptar_pkg::ST_INS_SCAN:
            begin
                if (key_hit)
                begin
                    pick_next  = idx_reg;
                    match_next = 1'b1;
                    idx_next   = '0;
                end
                else
                begin
                    if (rd.age > best_reg)
                    begin
                        best_next = rd.age;
                        pick_next = idx_reg;
                    end
                    idx_next = last ? '0 : idx_reg + 1'b1;
                end
            end
            kptar_pkg::ST_INS_AGE:
            begin
                if (idx_reg == pick_reg)
                begin
                    wr.wr_entry = 1'b1;
                    wr.age      = '0;
                end
                else if (rd.valid && (rd.age != kptar_pkg::AGE_MAX))
                begin
                    wr.wr_age = 1'b1;
                    wr.age    = rd.age + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (last)
                begin
                    if (!match_reg && (count_reg < n_act))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    done_next = 1'b1;
                    ok_next   = 1'b1;
                    upd_next  = match_reg;
                    oent_next = '0;
                    ovld_next = 1'b0;
                end
            end
            kptar_pkg::ST_FORGET:
            begin
                wr.clr_valid = addr_hit;
                removed_next = rem_total;
                idx_next     = idx_reg + 1'b1;
                if (last)
                begin
                    count_next = (rem_total >= count_reg) ? '0 : count_reg - rem_total;
                    done_next  = 1'b1;
                    ok_next    = (rem_total != '0);
                    upd_next   = 1'b0;
                    oent_next  = '0;
                    ovld_next  = 1'b0;
                end
            end
            kptar_pkg::ST_READ:
            begin
                oent_next = rd.entry;
                ovld_next = rd.valid;
                modv_next = kptar_pkg::CNT_W'(rdidx_reg) + kptar_pkg::CNT_W'(1);
            end
            kptar_pkg::ST_MOD:
            begin
                if (modv_reg >= count_reg)
                begin
                    modv_next = modv_reg - count_reg;
                end
                else
                begin
                    rdidx_next = modv_reg[kptar_pkg::IDX_W-1:0];
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    upd_next   = 1'b0;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kptar_pkg::ST_IDLE;
            siu_reg     <= kptar_pkg::SLOTS_IN_USE_RESET;
            idx_reg     <= '0;
            pick_reg    <= '0;
            best_reg    <= '0;
            match_reg   <= 1'b0;
            removed_reg <= '0;
            count_reg   <= '0;
            rdidx_reg   <= '0;
            modv_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pick_reg    <= pick_next;
            best_reg    <= best_next;
            match_reg   <= match_next;
            removed_reg <= removed_next;
            count_reg   <= count_next;
            rdidx_reg   <= rdidx_next;
            modv_reg    <= modv_next;
            done_reg    <= done_next;
            if (cfg_we)
            begin
                siu_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        kind_reg <= kind_next;
        req_reg  <= req_next;
        ok_reg   <= ok_next;
        upd_reg  <= upd_next;
        oent_reg <= oent_next;
        ovld_reg <= ovld_next;
    end

    assign busy             = (state_reg != kptar_pkg::ST_IDLE);
    assign done             = done_reg;
    assign ok               = ok_reg;
    assign updated_existing = upd_reg;
    assign out_address      = oent_reg.address;
    assign out_kind         = oent_reg.kind;
    assign out_repeat       = oent_reg.rpt;
    assign out_payload      = oent_reg.payload;
    assign out_payload_len  = oent_reg.len;
    assign out_slot_valid   = ovld_reg;

    a_done_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy || start))
        else $error("result strobe without a request in progress");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= kptar_pkg::SLOTS)
        else $error("stored count above slot count");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done_reg))
        else $error("accepted request neither started nor answered");

    a_update_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && upd_reg) |-> ok_reg)
        else $error("updated_existing without ok");

    a_read_index_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kptar_pkg::ST_MOD && modv_reg < count_reg) |=>
            (kptar_pkg::CNT_W'(rdidx_reg) < $past(count_reg)))
        else $error("read index not wrapped below count");

endmodule
